// ===== src/lcdns_pkg.sv =====
package lcdns_pkg;

    // Request kinds.
    localparam logic [2:0] KIND_INIT      = 3'd0;
    localparam logic [2:0] KIND_COMMAND   = 3'd1;
    localparam logic [2:0] KIND_DATA      = 3'd2;
    localparam logic [2:0] KIND_CURSOR    = 3'd3;
    localparam logic [2:0] KIND_BACKLIGHT = 3'd4;

    // Fixed LCD command bytes.
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;

    localparam logic [2:0] ROW_COUNT_RESET = 3'd2;

    // Job queue between the classifier and the sequencer.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;

    // Nibble and phase counters of the sequencer.
    localparam logic [3:0] INIT_LAST_NIB = 4'd13;
    localparam logic [3:0] BYTE_LAST_NIB = 4'd1;
    localparam logic [1:0] PHASE_PRE     = 2'd0;
    localparam logic [1:0] PHASE_STROBE  = 2'd1;
    localparam logic [1:0] PHASE_POST    = 2'd2;

    localparam logic [5:0] INIT_WAIT_BEFORE = 6'd50;
    localparam logic [2:0] NIBBLE_WAIT      = 3'd2;

    // One unit of work for the sequencer.
    typedef struct packed {
        logic       is_init;
        logic [7:0] data;
        logic       rs;
        logic       bl;
    } job_t;

    // DDRAM address of the first cell of each row.
    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            2'd3:    base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

    // Nibble sent at each step of the power-up sequence.
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        case (idx)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3, 4'd4:       nib = 4'h2;
            4'd5, 4'd7:       nib = 4'h8;
            4'd9:             nib = 4'h1;
            4'd11:            nib = 4'h6;
            4'd13:            nib = 4'hC;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

    // Settle time after each nibble of the power-up sequence.
    function automatic logic [2:0] init_wait(input logic [3:0] idx);
        logic [2:0] w;
        case (idx)
            4'd0:             w = 3'd7;
            4'd1, 4'd2, 4'd3: w = 3'd3;
            4'd9:             w = 3'd4;
            default:          w = NIBBLE_WAIT;
        endcase
        return w;
    endfunction

endpackage

// ===== src/lcdns_front.sv =====
module lcdns_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [2:0]          kind,
    input  logic [7:0]          value,
    input  logic [5:0]          column,
    input  logic [1:0]          row,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_data,
    input  logic                fifo_full,
    output logic                push,
    output lcdns_pkg::job_t     push_job
);
    import lcdns_pkg::*;

    logic [2:0] row_count_reg;
    logic       bl_reg;
    logic       accept;
    logic       useful;
    logic [7:0] cursor_addr;

    assign req_stall   = fifo_full;
    assign accept      = req_valid && !req_stall;
    assign cursor_addr = row_base(row) + {2'b00, column};

    always_comb
    begin
        useful           = 1'b0;
        push_job.is_init = 1'b0;
        push_job.data    = value;
        push_job.rs      = 1'b0;
        push_job.bl      = bl_reg;
        case (kind)
            KIND_INIT:
            begin
                useful           = 1'b1;
                push_job.is_init = 1'b1;
            end
            KIND_COMMAND:
            begin
                useful = 1'b1;
            end
            KIND_DATA:
            begin
                useful      = 1'b1;
                push_job.rs = 1'b1;
            end
            KIND_CURSOR:
            begin
                useful        = ({1'b0, row} < row_count_reg);
                push_job.data = CMD_SET_DDRAM | cursor_addr;
            end
            KIND_BACKLIGHT:
            begin
                useful        = 1'b1;
                push_job.data = CMD_DISPLAY_ON;
                push_job.bl   = 1'b1;
            end
            default:
            begin
                useful = 1'b0;
            end
        endcase
    end

    assign push = accept && useful;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RESET;
            bl_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                row_count_reg <= cfg_data;
            end
            if (accept && kind == KIND_BACKLIGHT)
            begin
                bl_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== src/lcdns_fifo.sv =====
module lcdns_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lcdns_pkg::job_t     push_job,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output lcdns_pkg::job_t     head_job
);
    import lcdns_pkg::*;

    job_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign full       = (count_reg == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/lcdns_back.sv =====
module lcdns_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  lcdns_pkg::job_t     head_job,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_stall,
    output logic [7:0]          port_byte,
    output logic [5:0]          wait_before_ms,
    output logic [2:0]          wait_after_ms,
    output logic                last
);
    import lcdns_pkg::*;

    logic [3:0] nib_reg;
    logic [1:0] phase_reg;
    logic       out_valid_reg;
    logic [7:0] port_byte_reg;
    logic [5:0] wait_before_reg;
    logic [2:0] wait_after_reg;
    logic       last_reg;

    logic       advance;
    logic       nib_done;
    logic       job_done;
    logic [3:0] nib_last;
    logic [3:0] nibble;
    logic [2:0] settle;
    logic [7:0] port_byte_next;
    logic [5:0] wait_before_next;
    logic [2:0] wait_after_next;

    assign advance  = head_valid && (!out_valid_reg || !res_stall);
    assign nib_last = head_job.is_init ? INIT_LAST_NIB : BYTE_LAST_NIB;
    assign nib_done = (phase_reg == PHASE_POST);
    assign job_done = nib_done && (nib_reg == nib_last);
    assign pop      = advance && job_done;

    always_comb
    begin
        if (head_job.is_init)
        begin
            nibble = init_nibble(nib_reg);
            settle = init_wait(nib_reg);
        end
        else
        begin
            nibble = (nib_reg == 4'd0) ? head_job.data[7:4] : head_job.data[3:0];
            settle = NIBBLE_WAIT;
        end
        port_byte_next   = {nibble, head_job.bl, (phase_reg == PHASE_STROBE), 1'b0,
                            head_job.rs};
        wait_before_next = (head_job.is_init && nib_reg == 4'd0 && phase_reg == PHASE_PRE)
                           ? INIT_WAIT_BEFORE : 6'd0;
        wait_after_next  = nib_done ? settle : 3'd0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            port_byte_reg   <= port_byte_next;
            wait_before_reg <= wait_before_next;
            wait_after_reg  <= wait_after_next;
            last_reg        <= job_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_reg       <= '0;
            phase_reg     <= PHASE_PRE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (nib_done)
                begin
                    phase_reg <= PHASE_PRE;
                    nib_reg   <= job_done ? 4'd0 : nib_reg + 4'd1;
                end
                else
                begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid      = out_valid_reg;
    assign port_byte      = port_byte_reg;
    assign wait_before_ms = wait_before_reg;
    assign wait_after_ms  = wait_after_reg;
    assign last           = last_reg;

endmodule

// ===== src/char_lcd_nibble_sequencer_top.sv =====
// With the sequencer idle, a request beat is written into the job queue and the sequencer's
// output register then presents the first port byte of the request.
// Throughput: one port byte per cycle while the sink does not stall; six port writes for a
// command, data, cursor or backlight request and forty-two for initialise; ignored requests
// take no sequencer time. The sequencer's nibble and phase counters set these counts.
// Reset: backlight off, row count 2, job queue and output register empty.
module char_lcd_nibble_sequencer_top (
    input  logic       clk,
    input  logic       rst_n,
    // Request channel.
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [2:0] kind,
    input  logic [7:0] value,
    input  logic [5:0] column,
    input  logic [1:0] row,
    // Row count register.
    input  logic       cfg_we,
    input  logic [2:0] cfg_data,
    // Port byte channel.
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] port_byte,
    output logic [5:0] wait_before_ms,
    output logic [2:0] wait_after_ms,
    output logic       last
);
    import lcdns_pkg::*;

    // The front end classifies each request beat into a job: either the fixed
    // power-up sequence or one LCD byte with its select and backlight bits.
    // Cursor requests on rows beyond the row count and unknown kinds are taken
    // but produce no job. The backlight bit is captured into each job, so jobs
    // already queued keep the backlight state they were issued under.
    logic fifo_full;
    logic push;
    job_t push_job;
    logic pop;
    logic head_valid;
    job_t head_job;

    lcdns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .value     (value),
        .column    (column),
        .row       (row),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .fifo_full (fifo_full),
        .push      (push),
        .push_job  (push_job)
    );

    // A two-entry queue decouples the front end from the sequencer, so new
    // requests are taken while an earlier job is still being played out.
    lcdns_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // The sequencer walks the job at the head of the queue, three port writes
    // per nibble with enable low, high and low, and pops the job after its
    // final write. Its output register holds a beat while the sink stalls.
    lcdns_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_job       (head_job),
        .pop            (pop),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .port_byte      (port_byte),
        .wait_before_ms (wait_before_ms),
        .wait_after_ms  (wait_after_ms),
        .last           (last)
    );

endmodule

// ===== dv/tb_char_lcd_nibble_sequencer_top.sv =====
`timescale 1ns / 100ps

// This bench checks the LCD nibble sequencer against a predictor of its own.
// Every request beat that is accepted is expanded here into the port writes it
// should cause. Each port write beat that leaves the block is then checked,
// field by field, against the oldest one still waiting.
module tb_char_lcd_nibble_sequencer_top;

    import lcdns_pkg::*;

    // Bits of the expander port byte.
    localparam logic [7:0] PORT_EN = 8'h04;
    localparam logic [7:0] PORT_BL = 8'h08;
    localparam logic [7:0] PORT_RS = 8'h01;

    // Commands and nibbles of the power-up sequence.
    localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIBBLE  = 4'h2;
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [5:0] POWER_UP_WAIT_MS = 6'd50;
    localparam logic [2:0] SETTLE_MS        = 3'd2;

    // Kinds that the block must ignore.
    localparam logic [2:0] KIND_UNUSED_FIRST = KIND_BACKLIGHT + 3'd1;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

    // DDRAM address of the first cell of rows 0 to 3, row 0 in the low byte.
    localparam logic [31:0] ROW_STARTS = {8'h54, 8'h14, 8'h40, 8'h00};

    // The first port write of a request passes through the job queue and the output register; a few spare
    // cycles cover a request that the block drops without any output.
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 40;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [5:0] column;
        logic [1:0] row;
        logic       hold_for_drain;
    } lcd_request_t;

    typedef struct packed {
        logic [7:0] port_byte;
        logic [5:0] wait_before;
        logic [2:0] wait_after;
        logic       last;
    } port_write_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    logic [2:0] kind = KIND_INIT;
    logic [7:0] value = 8'h00;
    logic [5:0] column = 6'd0;
    logic [1:0] row = 2'd0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_data = ROW_COUNT_RESET;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [7:0] port_byte;
    logic [5:0] wait_before_ms;
    logic [2:0] wait_after_ms;
    logic       last;

    // Requests still to be driven, and port writes still to arrive.
    lcd_request_t request_q[$];
    port_write_t  port_write_q[$];
    lcd_request_t in_flight;

    // The predictor's own copy of the block's register and state.
    logic [2:0] rows_model = ROW_COUNT_RESET;
    logic       backlight_model = 1'b0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;

    char_lcd_nibble_sequencer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .kind           (kind),
        .value          (value),
        .column         (column),
        .row            (row),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .port_byte      (port_byte),
        .wait_before_ms (wait_before_ms),
        .wait_after_ms  (wait_after_ms),
        .last           (last)
    );

    always #5 clk = ~clk;

    // Every failure goes through here. Printing stops after a while so that a
    // badly broken block does not flood the log, but the count carries on.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // One nibble is three port writes: enable low, high, then low again. Only
    // the third carries a settle time, which is the usual 2 ms plus any extra.
    function automatic void queue_nibble(input logic [3:0] nib, input logic rs,
                                         input logic [5:0] wait_first,
                                         input logic [2:0] extra);
        port_write_t w;
        logic [7:0]  base;
        base = {nib, 4'h0} | (backlight_model ? PORT_BL : 8'h00) | (rs ? PORT_RS : 8'h00);
        w.port_byte   = base;
        w.wait_before = wait_first;
        w.wait_after  = 3'd0;
        w.last        = 1'b0;
        port_write_q.push_back(w);
        w.port_byte   = base | PORT_EN;
        w.wait_before = 6'd0;
        port_write_q.push_back(w);
        w.port_byte   = base;
        w.wait_after  = SETTLE_MS + extra;
        port_write_q.push_back(w);
    endfunction

    // A byte goes out high nibble first; any extra settle time follows the low one.
    function automatic void queue_byte(input logic [7:0] b, input logic rs,
                                       input logic [2:0] extra);
        queue_nibble(b[7:4], rs, 6'd0, 3'd0);
        queue_nibble(b[3:0], rs, 6'd0, extra);
    endfunction

    // Expands one accepted request into the port writes that it should cause.
    function automatic void expand_request(input lcd_request_t q);
        int          first;
        port_write_t w;
        logic [7:0]  addr;
        first = port_write_q.size();
        case (q.kind)
            KIND_INIT:
            begin
                // The three wake-up nibbles, the switch to four bits, then
                // the usual set-up commands. Clearing needs extra time.
                queue_nibble(WAKE_NIBBLE, 1'b0, POWER_UP_WAIT_MS, 3'd5);
                queue_nibble(WAKE_NIBBLE, 1'b0, 6'd0, 3'd1);
                queue_nibble(WAKE_NIBBLE, 1'b0, 6'd0, 3'd1);
                queue_nibble(FOUR_BIT_NIBBLE, 1'b0, 6'd0, 3'd1);
                queue_byte(CMD_FUNCTION_SET, 1'b0, 3'd0);
                queue_byte(CMD_DISPLAY_OFF, 1'b0, 3'd0);
                queue_byte(CMD_CLEAR, 1'b0, 3'd2);
                queue_byte(CMD_ENTRY_MODE, 1'b0, 3'd0);
                queue_byte(CMD_DISPLAY_ON, 1'b0, 3'd0);
            end
            KIND_COMMAND:
            begin
                queue_byte(q.value, 1'b0, 3'd0);
            end
            KIND_DATA:
            begin
                queue_byte(q.value, 1'b1, 3'd0);
            end
            KIND_CURSOR:
            begin
                // Rows at or above the row count are dropped; the address
                // simply wraps at eight bits.
                if ({1'b0, q.row} < rows_model)
                begin
                    addr = ROW_STARTS[q.row * 8 +: 8] + {2'b00, q.column};
                    queue_byte(CMD_SET_DDRAM | addr, 1'b0, 3'd0);
                end
            end
            KIND_BACKLIGHT:
            begin
                backlight_model = 1'b1;
                queue_byte(CMD_DISPLAY_ON, 1'b0, 3'd0);
            end
            default:
            begin
            end
        endcase
        if (port_write_q.size() > first)
        begin
            w = port_write_q.pop_back();
            w.last = 1'b1;
            port_write_q.push_back(w);
        end
    endfunction

    // Request driver. A new request is loaded only when the slot is free: no
    // beat is held, or the held beat is taken at this very edge. A request
    // marked to wait for the drain holds back until every port write is in.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expand_request(in_flight);
            end
            if (!req_valid || !req_stall)
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                    && !(request_q[0].hold_for_drain && port_write_q.size() != 0))
                begin
                    in_flight = request_q.pop_front();
                    req_valid <= 1'b1;
                    kind      <= in_flight.kind;
                    value     <= in_flight.value;
                    column    <= in_flight.column;
                    row       <= in_flight.row;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // The port write side stalls at random in the phases that ask for it.
    always @(posedge clk)
    begin
        res_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // Port write monitor: each beat taken is matched with the oldest expectation.
    always @(posedge clk)
    begin : port_write_monitor
        port_write_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (port_write_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected port write %02h", port_byte));
            end
            else
            begin
                want = port_write_q.pop_front();
                if (port_byte !== want.port_byte)
                    report_mismatch($sformatf("port_byte %02h, expected %02h",
                                              port_byte, want.port_byte));
                if (wait_before_ms !== want.wait_before)
                    report_mismatch($sformatf("wait_before_ms %0d, expected %0d (byte %02h)",
                                              wait_before_ms, want.wait_before,
                                              want.port_byte));
                if (wait_after_ms !== want.wait_after)
                    report_mismatch($sformatf("wait_after_ms %0d, expected %0d (byte %02h)",
                                              wait_after_ms, want.wait_after,
                                              want.port_byte));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b (byte %02h)",
                                              last, want.last, want.port_byte));
            end
        end
    end

    task automatic add_request(input logic [2:0] k, input logic [7:0] v,
                               input logic [5:0] c, input logic [1:0] r,
                               input logic hold);
        lcd_request_t q;
        q.kind           = k;
        q.value          = v;
        q.column         = c;
        q.row            = r;
        q.hold_for_drain = hold;
        request_q.push_back(q);
    endtask

    // Random requests lean towards single bytes, with the odd power-up
    // sequence, backlight request and ignored kind mixed in.
    task automatic add_random_request();
        int          pick;
        logic [2:0]  k;
        logic [5:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            k = KIND_INIT;
        else if (pick < 8)
            k = KIND_BACKLIGHT;
        else if (pick < 13)
            k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        else if (pick < 45)
            k = KIND_COMMAND;
        else if (pick < 70)
            k = KIND_DATA;
        else
            k = KIND_CURSOR;
        if ($urandom_range(0, 9) == 0)
            c = 6'($urandom_range(0, 63));
        else
            c = 6'($urandom_range(0, 39));
        add_request(k, 8'($urandom_range(0, 255)), c, 2'($urandom_range(0, 3)),
                    $urandom_range(0, 19) == 0);
    endtask

    // Waits until every request is taken and every port write is in, then
    // lets a few cycles go by in case a dropped request is still in the block.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || req_valid || port_write_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Starts a new phase with a fresh row count and idling pattern.
    task automatic start_phase(input logic [2:0] rows, input int idle, input int stall);
        wait_drained();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= rows;
        @(posedge clk);
        cfg_we   <= 1'b0;
        rows_model    = rows;
        send_idle_pct = idle;
        stall_pct     = stall;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, still on the reset row count of two: power-up with
        // the backlight off, the extremes of command and data bytes, cursor
        // requests on both sides of the row count, ignored kinds, the
        // backlight request, and a data byte that waits for the drain.
        add_request(KIND_INIT, 8'h00, 6'd0, 2'd0, 1'b0);
        add_request(KIND_COMMAND, 8'h00, 6'd0, 2'd0, 1'b0);
        add_request(KIND_COMMAND, 8'hFF, 6'd0, 2'd0, 1'b0);
        add_request(KIND_DATA, 8'h00, 6'd0, 2'd0, 1'b0);
        add_request(KIND_DATA, 8'hFF, 6'd0, 2'd0, 1'b0);
        add_request(KIND_DATA, 8'h5A, 6'd0, 2'd0, 1'b0);
        add_request(KIND_CURSOR, 8'h00, 6'd0, 2'd0, 1'b0);
        add_request(KIND_CURSOR, 8'h00, 6'd39, 2'd1, 1'b0);
        add_request(KIND_CURSOR, 8'h00, 6'd5, 2'd2, 1'b0);
        add_request(KIND_CURSOR, 8'h00, 6'd39, 2'd3, 1'b0);
        add_request(KIND_UNUSED_FIRST, 8'hFF, 6'd63, 2'd3, 1'b0);
        add_request(KIND_UNUSED_LAST, 8'h00, 6'd0, 2'd0, 1'b0);
        add_request(KIND_BACKLIGHT, 8'h00, 6'd0, 2'd0, 1'b0);
        add_request(KIND_DATA, 8'hA5, 6'd0, 2'd0, 1'b1);
        add_request(KIND_INIT, 8'hFF, 6'd63, 2'd3, 1'b0);
        add_request(KIND_CURSOR, 8'h00, 6'd63, 2'd1, 1'b0);

        // Four rows: the far corners, with the address reaching 0x93.
        start_phase(3'd4, 0, 0);
        add_request(KIND_CURSOR, 8'h00, 6'd39, 2'd3, 1'b0);
        add_request(KIND_CURSOR, 8'h00, 6'd63, 2'd2, 1'b0);
        add_request(KIND_CURSOR, 8'h00, 6'd63, 2'd3, 1'b0);

        // No rows at all: every cursor request is dropped.
        start_phase(3'd0, 0, 0);
        add_request(KIND_CURSOR, 8'h00, 6'd0, 2'd0, 1'b0);
        add_request(KIND_COMMAND, 8'h3C, 6'd0, 2'd0, 1'b0);

        // The largest value the register holds.
        start_phase(3'd7, 0, 0);
        add_request(KIND_CURSOR, 8'h00, 6'd0, 2'd3, 1'b0);
        add_request(KIND_UNUSED_FIRST + 3'd1, 8'h00, 6'd0, 2'd0, 1'b0);

        // Random part, one idling pattern per phase.
        start_phase(3'd4, 0, 0);
        repeat (62) add_random_request();
        start_phase(3'd1, 45, 0);
        repeat (62) add_random_request();
        start_phase(3'd3, 0, 45);
        repeat (62) add_random_request();
        start_phase(3'd2, 23, 23);
        repeat (62) add_random_request();

        wait_drained();
        if (mismatch_count == 0)
        begin
            $display("tb_char_lcd_nibble_sequencer_top OK");
        end
        else
        begin
            $display("tb_char_lcd_nibble_sequencer_top NOT OK");
        end
        $finish;
    end

    // A hung handshake or a missing port write ends up here.
    initial
    begin
        #5_000_000;
        $display("tb_char_lcd_nibble_sequencer_top NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
src/lcdns_pkg.sv
src/lcdns_front.sv
src/lcdns_fifo.sv
src/lcdns_back.sv
src/char_lcd_nibble_sequencer_top.sv
dv/tb_char_lcd_nibble_sequencer_top.sv
